FILE: rtl/sab_pkg.sv
package sab_pkg;

	localparam int CH_W    = 8;
	localparam int NUM_CH  = 4;
	localparam int PIX_W   = CH_W * NUM_CH;
	localparam int NUM_SRC = 4;
	localparam int ALPHA_LSB = 24;
	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	// Register indexes on the configuration port.
	typedef enum logic [0:0] {
		REG_FRAC_X = 1'b0,
		REG_FRAC_Y = 1'b1
	} sab_reg_t;

	// Sprite neighbor order: here, right, below, below-right.
	typedef logic [PIX_W-1:0] sab_pix_t;

	typedef struct packed {
		logic [NUM_SRC-1:0][CH_W-1:0] w;
	} sab_weights_t;

	// Channel scaled by an 8-bit factor, truncated.
	function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] ch,
		input logic [CH_W-1:0] s);
		logic [2*CH_W-1:0] prod;
		prod = ch * s;
		return prod[2*CH_W-1:CH_W];
	endfunction

	// Channel sum, clamped to full scale.
	function automatic logic [CH_W-1:0] add_sat(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		logic [CH_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
	endfunction

endpackage

FILE: rtl/subpixel_sprite_alpha_blend_unit.sv
// Subpixel sprite alpha blend unit: the per-pixel core of a 2D blitter. Program the
// horizontal and vertical subpixel fractions through the APB port, then present one item
// per clock on the data ports with start high: four neighboring ARGB8888 sprite pixels
// and the destination pixel. Each item is accepted whenever start is high, since busy
// never rises; a new item can enter on every clock. The blended pixel appears on
// blended_pixel for exactly one cycle, marked by done, once the item has passed the stage
// one, two, three and four registers in turn; items leave in the order they entered. The
// receiver cannot stall the unit, so it must take every result in the cycle done is
// high. Throughput is one item per clock, and each item passes through the four
// pipeline stages: neighbor weighting, per-channel summing, the two alpha blend
// products, and their final sum. The four bilinear weights are derived from the
// fraction registers and held in registers of their own, which load at the same edge
// as the fraction write, so an item accepted right after a write already sees the new
// fractions; program the fractions only while no item is in flight. The weight on the
// pixel at the current position is (fx*fy)>>8, on the right neighbor ((255-fx)*fy)>>8,
// on the pixel below (fx*(255-fy))>>8, and on the pixel below and to the right
// ((255-fx)*(255-fy))>>8. frac_x is at byte address 0 and frac_y at byte address 4;
// both reset to zero.
module subpixel_sprite_alpha_blend_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] src_here,
	input  logic [31:0] src_right,
	input  logic [31:0] src_below,
	input  logic [31:0] src_below_right,
	input  logic [31:0] dest_pixel,
	output logic        done,
	output logic [31:0] blended_pixel
);

	sab_pkg::sab_weights_t wts;
	sab_pkg::sab_pix_t     pix_s2;
	sab_pkg::sab_pix_t     dst_s2;
	logic                  v_s2;
	logic                  accept;

	// The pipeline never backs up, so an item is taken on every cycle start is high.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	sab_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.wts    (wts)
	);

	// Stages one and two: weighted neighbors and their per-channel sum.
	sab_interp u_interp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (accept),
		.wts            (wts),
		.src_here       (src_here),
		.src_right      (src_right),
		.src_below      (src_below),
		.src_below_right(src_below_right),
		.dest_pixel     (dest_pixel),
		.v_s2           (v_s2),
		.pix_s2         (pix_s2),
		.dst_s2         (dst_s2)
	);

	// Stages three and four: the interpolated pixel's own alpha blends it over the
	// destination, and the result register drives the output ports directly.
	sab_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s2   (v_s2),
		.pix_s2 (pix_s2),
		.dst_s2 (dst_s2),
		.v_s4   (done),
		.res_s4 (blended_pixel)
	);

endmodule

FILE: rtl/sab_cfg.sv
module sab_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output sab_pkg::sab_weights_t wts
);

	logic [sab_pkg::CH_W-1:0] frac_x_q;
	logic [sab_pkg::CH_W-1:0] frac_y_q;
	logic [sab_pkg::CH_W-1:0] next_x;
	logic [sab_pkg::CH_W-1:0] next_y;
	logic [sab_pkg::CH_W-1:0] inv_x;
	logic [sab_pkg::CH_W-1:0] inv_y;
	sab_pkg::sab_weights_t    wts_q;
	sab_pkg::sab_weights_t    wts_d;
	sab_pkg::sab_reg_t        reg_sel;
	logic                     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = sab_pkg::sab_reg_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				sab_pkg::REG_FRAC_X: frac_x_q <= pwdata[sab_pkg::CH_W-1:0];
				sab_pkg::REG_FRAC_Y: frac_y_q <= pwdata[sab_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			sab_pkg::REG_FRAC_X: prdata[sab_pkg::CH_W-1:0] = frac_x_q;
			sab_pkg::REG_FRAC_Y: prdata[sab_pkg::CH_W-1:0] = frac_y_q;
			default: prdata = '0;
		endcase
	end

	// The weights are built from the fractions as they stand after this edge, so the
	// weight registers load at the same edge as the fraction that is written.
	assign next_x = (wr_en && reg_sel == sab_pkg::REG_FRAC_X) ?
		pwdata[sab_pkg::CH_W-1:0] : frac_x_q;
	assign next_y = (wr_en && reg_sel == sab_pkg::REG_FRAC_Y) ?
		pwdata[sab_pkg::CH_W-1:0] : frac_y_q;

	// Weight pairing: the fx*fy weight goes to the pixel at the current position.
	assign inv_x = sab_pkg::CH_MAX - next_x;
	assign inv_y = sab_pkg::CH_MAX - next_y;

	always_comb begin
		wts_d.w[0] = sab_pkg::scale_ch(next_x, next_y);
		wts_d.w[1] = sab_pkg::scale_ch(inv_x, next_y);
		wts_d.w[2] = sab_pkg::scale_ch(next_x, inv_y);
		wts_d.w[3] = sab_pkg::scale_ch(inv_x, inv_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wts_q <= '0;
		end else begin
			wts_q <= wts_d;
		end
	end

	assign wts = wts_q;

endmodule

FILE: rtl/sab_interp.sv
module sab_interp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  sab_pkg::sab_weights_t wts,
	input  sab_pkg::sab_pix_t     src_here,
	input  sab_pkg::sab_pix_t     src_right,
	input  sab_pkg::sab_pix_t     src_below,
	input  sab_pkg::sab_pix_t     src_below_right,
	input  sab_pkg::sab_pix_t     dest_pixel,
	output logic                  v_s2,
	output sab_pkg::sab_pix_t     pix_s2,
	output sab_pkg::sab_pix_t     dst_s2
);

	sab_pkg::sab_pix_t [sab_pkg::NUM_SRC-1:0] src;
	sab_pkg::sab_pix_t [sab_pkg::NUM_SRC-1:0] sc_d;
	sab_pkg::sab_pix_t [sab_pkg::NUM_SRC-1:0] sc_s1;
	sab_pkg::sab_pix_t                        dst_s1;
	sab_pkg::sab_pix_t                        pix_d;
	logic                                     v_s1;

	assign src[0] = src_here;
	assign src[1] = src_right;
	assign src[2] = src_below;
	assign src[3] = src_below_right;

	// Stage 1: every neighbor channel times its weight.
	always_comb begin
		for (int n = 0; n < sab_pkg::NUM_SRC; n++) begin
			for (int k = 0; k < sab_pkg::NUM_CH; k++) begin
				sc_d[n][k*sab_pkg::CH_W +: sab_pkg::CH_W] =
					sab_pkg::scale_ch(src[n][k*sab_pkg::CH_W +: sab_pkg::CH_W], wts.w[n]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			sc_s1  <= sc_d;
			dst_s1 <= dest_pixel;
		end
	end

	// Stage 2: pairwise clamped sums per channel, no carry between channels.
	always_comb begin
		for (int k = 0; k < sab_pkg::NUM_CH; k++) begin
			pix_d[k*sab_pkg::CH_W +: sab_pkg::CH_W] = sab_pkg::add_sat(
				sab_pkg::add_sat(sc_s1[0][k*sab_pkg::CH_W +: sab_pkg::CH_W],
					sc_s1[1][k*sab_pkg::CH_W +: sab_pkg::CH_W]),
				sab_pkg::add_sat(sc_s1[2][k*sab_pkg::CH_W +: sab_pkg::CH_W],
					sc_s1[3][k*sab_pkg::CH_W +: sab_pkg::CH_W]));
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			pix_s2 <= pix_d;
			dst_s2 <= dst_s1;
		end
	end

endmodule

FILE: rtl/sab_blend.sv
module sab_blend (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_s2,
	input  sab_pkg::sab_pix_t pix_s2,
	input  sab_pkg::sab_pix_t dst_s2,
	output logic              v_s4,
	output sab_pkg::sab_pix_t res_s4
);

	logic [sab_pkg::CH_W-1:0] alpha;
	logic [sab_pkg::CH_W-1:0] inv_alpha;
	sab_pkg::sab_pix_t        src_d;
	sab_pkg::sab_pix_t        dst_d;
	sab_pkg::sab_pix_t        src_s3;
	sab_pkg::sab_pix_t        dst_s3;
	sab_pkg::sab_pix_t        res_d;
	logic                     v_s3;

	assign alpha     = pix_s2[sab_pkg::ALPHA_LSB +: sab_pkg::CH_W];
	assign inv_alpha = sab_pkg::CH_MAX - alpha;

	// Stage 3: both blend terms, alpha channel included.
	always_comb begin
		for (int k = 0; k < sab_pkg::NUM_CH; k++) begin
			src_d[k*sab_pkg::CH_W +: sab_pkg::CH_W] =
				sab_pkg::scale_ch(pix_s2[k*sab_pkg::CH_W +: sab_pkg::CH_W], alpha);
			dst_d[k*sab_pkg::CH_W +: sab_pkg::CH_W] =
				sab_pkg::scale_ch(dst_s2[k*sab_pkg::CH_W +: sab_pkg::CH_W], inv_alpha);
		end
	end

	// Stage 4: clamped per-channel sum of the two terms.
	always_comb begin
		for (int k = 0; k < sab_pkg::NUM_CH; k++) begin
			res_d[k*sab_pkg::CH_W +: sab_pkg::CH_W] = sab_pkg::add_sat(
				src_s3[k*sab_pkg::CH_W +: sab_pkg::CH_W],
				dst_s3[k*sab_pkg::CH_W +: sab_pkg::CH_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			src_s3 <= src_d;
			dst_s3 <= dst_d;
		end
		if (v_s3) begin
			res_s4 <= res_d;
		end
	end

endmodule
